[rtl/core/deq_pkg.sv]
`default_nettype none
package deq_pkg;

    localparam int DEQ_DEPTH   = 16;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int CNT_OUT_W   = 5;
    localparam int STATUS_W    = 2;

    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = OP_W;
    localparam int OUT_DATA_W  = 72;

    localparam int FRONT_LSB   = 0;
    localparam int BACK_LSB    = 32;
    localparam int CNT_LSB     = 64;
    localparam int EMPTY_BIT   = 69;
    localparam int STATUS_LSB  = 70;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_deq_cmd;

endpackage
`default_nettype wire

[rtl/core/deq_ram.sv]
`default_nettype none
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

[rtl/core/deq_ctrl.sv]
`default_nettype none
module deq_ctrl (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output deq_pkg::t_deq_cmd o_cmd
);

    import deq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state   r_state;
    t_state   n_state;
    logic     r_out_valid;
    logic     n_out_valid;
    t_deq_cmd w_cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                w_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // output register free or emptying this cycle
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule
`default_nettype wire

[rtl/core/deq_dp.sv]
`default_nettype none
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire deq_pkg::t_deq_cmd                 i_cmd,
    input  wire logic [deq_pkg::OP_W-1:0]          i_opcode,
    input  wire logic [deq_pkg::DATA_W-1:0]        i_push_value,
    output logic      [deq_pkg::DATA_W-1:0]        o_front_value,
    output logic      [deq_pkg::DATA_W-1:0]        o_back_value,
    output logic      [deq_pkg::CNT_OUT_W-1:0]     o_entry_count,
    output logic                                   o_is_empty,
    output logic      [deq_pkg::STATUS_W-1:0]      o_status
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [OP_W-1:0]      r_op;
    logic [DATA_W-1:0]    r_val;
    logic [AW-1:0]        r_head;
    logic [AW-1:0]        n_head;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [STATUS_W-1:0]  r_status;
    logic [STATUS_W-1:0]  n_status;

    logic [DATA_W-1:0]    r_front;
    logic [DATA_W-1:0]    r_back;
    logic [CNT_OUT_W-1:0] r_cnt_out;
    logic                 r_empty;
    logic [STATUS_W-1:0]  r_st_out;

    logic                 w_full;
    logic                 w_none;
    logic [AW-1:0]        w_head_dec;
    logic [AW-1:0]        w_head_inc;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr_b;
    logic [DATA_W-1:0]    w_rdata_a;
    logic [DATA_W-1:0]    w_rdata_b;

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_none     = (r_count == '0);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        w_we     = 1'b0;
        w_waddr  = wrap_add(r_head, r_count);
        if (i_cmd.exec) begin
            case (r_op)
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_PUSH_FULL;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_PUSH_FULL;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = w_head_dec;
                        n_head  = w_head_dec;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (w_none) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        n_head  = w_head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (w_none) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // back entry sits at head + count - 1; address is junk when empty
    assign w_raddr_b = wrap_add(r_head, r_count - 1'b1);

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (r_val),
        .i_raddr_a (r_head),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.load) begin
            r_front   <= w_none ? EMPTY_VALUE : w_rdata_a;
            r_back    <= w_none ? EMPTY_VALUE : w_rdata_b;
            r_cnt_out <= CNT_OUT_W'(r_count);
            r_empty   <= w_none;
            r_st_out  <= r_status;
        end
    end

    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_entry_count = r_cnt_out;
    assign o_is_empty    = r_empty;
    assign o_status      = r_st_out;

endmodule
`default_nettype wire

[rtl/core/double_ended_queue_unit.sv]
// Bounded double-ended queue of signed 32-bit values, DEPTH entries.
// Input stream (s_axis): one beat is one operation. tuser carries the opcode
// (push back, push front, pop front, pop back, anything else is a query),
// tdata the value to push.
// Output stream (m_axis): one beat per operation with the front and back
// values (-1 when empty), entry count, empty flag and status
// (ok, pop on empty ignored, push on full ignored).
// The sequencer walks capture, queue update with RAM write, RAM read of front
// and back, and result load; the result beat becomes valid with the load, and
// the next operation is accepted only after that load.
// s_axis_tready is high only while the sequencer is idle.
// The output register lets the next operation be accepted while a result
// waits; if the receiver stalls, the following result is held back at the
// load step until the output register drains.
// Reset (synchronous, active low) empties the queue and drops any result;
// storage contents are not cleared and need no clearing time.
// The entry count is reported in 5 bits.
`default_nettype none
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] push_value
    input  wire logic [deq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] opcode
    input  wire logic [deq_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] front_value, [63:32] back_value, [68:64] entry_count,
    // [69] is_empty, [71:70] status
    output logic      [deq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    import deq_pkg::*;

    t_deq_cmd             w_cmd;
    logic [DATA_W-1:0]    w_front;
    logic [DATA_W-1:0]    w_back;
    logic [CNT_OUT_W-1:0] w_count;
    logic                 w_empty;
    logic [STATUS_W-1:0]  w_status;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (s_axis_tuser),
        .i_push_value  (s_axis_tdata),
        .o_front_value (w_front),
        .o_back_value  (w_back),
        .o_entry_count (w_count),
        .o_is_empty    (w_empty),
        .o_status      (w_status)
    );

    assign m_axis_tdata = {w_status, w_empty, w_count, w_back, w_front};

endmodule
`default_nettype wire

[rtl/core/deq_chk.sv]
`default_nettype none
module deq_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [deq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import deq_pkg::*;

    logic [STATUS_W-1:0] w_st;
    logic                w_empty;

    assign w_st    = m_axis_tdata[STATUS_LSB +: STATUS_W];
    assign w_empty = m_axis_tdata[EMPTY_BIT];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken while an operation is in flight");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_empty |->
            (m_axis_tdata[FRONT_LSB +: DATA_W] == EMPTY_VALUE) &&
            (m_axis_tdata[BACK_LSB +: DATA_W] == EMPTY_VALUE))
        else $error("empty queue reports values other than -1");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_st == ST_POP_EMPTY) |-> w_empty)
        else $error("pop on empty flagged on a non-empty queue");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_st == ST_PUSH_FULL) |-> !w_empty)
        else $error("push on full flagged on an empty queue");

endmodule

bind double_ended_queue_unit deq_chk u_deq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
